[src/prj_pkg.sv]
// Shared types, constants and helpers for the pinhole radial distortion projector.
package prj_pkg;

  localparam int VAL_W       = 63;
  localparam int MAG_W       = VAL_W - 1;
  localparam int SUM_W       = VAL_W + 1;
  localparam int CAM_W       = 49;
  localparam int DEN_W       = CAM_W - 1;
  localparam int FRAC        = 24;
  localparam int CAM_SHIFT   = 16;
  localparam int TRANS_SHIFT = 14;
  localparam int SAT_SHIFT   = MAG_W - FRAC;
  localparam int DIV_STEPS   = MAG_W;
  localparam int DIV_LAT     = DIV_STEPS + 2;
  localparam int MUL_LAT     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 32;
  localparam int PIX_W       = 32;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [CAM_W-1:0] cam_t;

  localparam val_t LIM     = {1'b0, {MAG_W{1'b1}}};
  localparam val_t ONE_Q24 = 63'sd16777216;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_U = 3'd2,
    REG_CENTER_V = 3'd3,
    REG_DIST_K1  = 3'd4,
    REG_DIST_K2  = 3'd5
  } cfg_reg_e;

  function automatic val_t sat_add(val_t a, val_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(b);
    if (s > sum_t'(LIM)) begin
      return LIM;
    end else if (s < -sum_t'(LIM)) begin
      return -LIM;
    end
    return val_t'(s);
  endfunction

endpackage

[src/prj_mul.sv]
// Pipelined signed multiply, truncating shift toward zero and saturation to +-LIM.
module prj_mul import prj_pkg::*; #(
  parameter int Shift = FRAC
) (
  input  logic clk_i,
  input  logic en_i,
  input  val_t a_i,
  input  val_t b_i,
  output val_t p_o
);

  localparam int HALF   = MAG_W / 2;
  localparam int PROD_W = 2 * MAG_W;

  logic [MAG_W-1:0]  ma, mb;
  logic [MAG_W-1:0]  p0_q, p1_q, p2_q, p3_q, p0_2q, p3_2q;
  logic [MAG_W:0]    mid_q;
  logic [PROD_W-1:0] sum_q, sh;
  logic [MAG_W-1:0]  mag;
  logic              neg1_q, neg2_q, neg3_q;
  val_t              p_q;

  always_comb begin
    ma  = a_i[VAL_W-1] ? MAG_W'(-a_i) : MAG_W'(a_i);
    mb  = b_i[VAL_W-1] ? MAG_W'(-b_i) : MAG_W'(b_i);
    sh  = sum_q >> Shift;
    mag = (|sh[PROD_W-1:MAG_W]) ? LIM[MAG_W-1:0] : sh[MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= ma[HALF-1:0] * mb[HALF-1:0];
      p1_q   <= ma[HALF-1:0] * mb[MAG_W-1:HALF];
      p2_q   <= ma[MAG_W-1:HALF] * mb[HALF-1:0];
      p3_q   <= ma[MAG_W-1:HALF] * mb[MAG_W-1:HALF];
      neg1_q <= a_i[VAL_W-1] ^ b_i[VAL_W-1];
      mid_q  <= (MAG_W+1)'(p1_q) + (MAG_W+1)'(p2_q);
      p0_2q  <= p0_q;
      p3_2q  <= p3_q;
      neg2_q <= neg1_q;
      sum_q  <= {p3_2q, p0_2q} + (PROD_W'(mid_q) << HALF);
      neg3_q <= neg2_q;
      p_q    <= neg3_q ? -val_t'({1'b0, mag}) : val_t'({1'b0, mag});
    end
  end

  assign p_o = p_q;

endmodule

[src/prj_div.sv]
// Pipelined restoring divider: two Q.24 quotients over one shared positive divisor.
module prj_div import prj_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  cam_t num_x_i,
  input  cam_t num_y_i,
  input  cam_t den_i,
  output val_t quo_x_o,
  output val_t quo_y_o
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [MAG_W-1:0] rq;
    logic             neg;
    logic             sat;
  } lane_t;

  lane_t [DIV_STEPS:0]            x_q, y_q;
  logic  [DIV_STEPS-1:0][DEN_W-1:0] den_q;
  val_t                           quo_x_q, quo_y_q;

  function automatic lane_t div_prep(cam_t num, logic [DEN_W-1:0] b);
    lane_t            l;
    logic [DEN_W-1:0] m;
    m     = num[CAM_W-1] ? DEN_W'(-num) : DEN_W'(num);
    l.neg = num[CAM_W-1];
    l.sat = DEN_W'(m[DEN_W-1:SAT_SHIFT]) >= b;
    l.rem = DEN_W'(m[DEN_W-1:SAT_SHIFT]);
    l.rq  = {m[SAT_SHIFT-1:0], {FRAC{1'b0}}};
    return l;
  endfunction

  function automatic lane_t div_step(lane_t l, logic [DEN_W-1:0] b);
    lane_t        n;
    logic [DEN_W:0] r2;
    logic           ge;
    r2    = {l.rem, l.rq[MAG_W-1]};
    ge    = r2 >= {1'b0, b};
    n     = l;
    n.rem = ge ? DEN_W'(r2 - {1'b0, b}) : DEN_W'(r2);
    n.rq  = {l.rq[MAG_W-2:0], ge};
    return n;
  endfunction

  function automatic val_t div_fin(lane_t l);
    val_t q;
    q = l.sat ? LIM : val_t'({1'b0, l.rq});
    return l.neg ? -q : q;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= div_prep(num_x_i, den_i[DEN_W-1:0]);
      y_q[0]   <= div_prep(num_y_i, den_i[DEN_W-1:0]);
      den_q[0] <= den_i[DEN_W-1:0];
      for (int i = 0; i < DIV_STEPS; i++) begin
        x_q[i+1] <= div_step(x_q[i], den_q[i]);
        y_q[i+1] <= div_step(y_q[i], den_q[i]);
      end
      for (int i = 1; i < DIV_STEPS; i++) begin
        den_q[i] <= den_q[i-1];
      end
      quo_x_q <= div_fin(x_q[DIV_STEPS]);
      quo_y_q <= div_fin(y_q[DIV_STEPS]);
    end
  end

  assign quo_x_o = quo_x_q;
  assign quo_y_o = quo_y_q;

endmodule

[src/pinhole_radial_distortion_projector_core.sv]
// Top level: pinhole projection with two-term radial distortion, fixed point pipeline.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------------
//   input   | in_valid_i / in_stall_o  | world_x/y, rot_11..rot_32, trans_x/y/z
//   output  | out_valid_o / out_stall_i| pixel_u, pixel_v, depth_invalid
//   config  | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while out_stall_i does not hold a valid result; the pipeline
// depth is set by the 62-step divider and six chained multiplier stages.
// Reset clears the valid pipe and loads the register defaults.
// A stalled result freezes the whole pipe; in_stall_o follows it in the same cycle.
module pinhole_radial_distortion_projector_core import prj_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [31:0]      world_x_i,
  input  logic signed [31:0]      world_y_i,
  input  logic signed [31:0]      rot_11_i,
  input  logic signed [31:0]      rot_21_i,
  input  logic signed [31:0]      rot_31_i,
  input  logic signed [31:0]      rot_12_i,
  input  logic signed [31:0]      rot_22_i,
  input  logic signed [31:0]      rot_32_i,
  input  logic signed [31:0]      trans_x_i,
  input  logic signed [31:0]      trans_y_i,
  input  logic signed [31:0]      trans_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PIX_W-1:0] pixel_u_o,
  output logic signed [PIX_W-1:0] pixel_v_o,
  output logic                    depth_invalid_o
);

  localparam int TOTAL_LAT = 6 * MUL_LAT + DIV_LAT + 4;
  localparam int XN_DLY    = 3 * MUL_LAT + 2;
  localparam int FLAG_DLY  = TOTAL_LAT - MUL_LAT - 1;
  localparam val_t S32_MAX = val_t'(64'sh7FFF_FFFF);
  localparam val_t S32_MIN = -val_t'(64'sh8000_0000);
  localparam logic [PIX_W-1:0] PIX_SAT = 32'h7FFF_FFFF;

  logic [30:0]        focal_x_q, focal_y_q;
  logic signed [31:0] center_u_q, center_v_q, dist_k1_q, dist_k2_q;

  logic                   en;
  logic [TOTAL_LAT-1:0]   valid_q;
  logic [FLAG_DLY-1:0]    flag_q;
  logic [MUL_LAT-1:0][31:0] tx_q, ty_q, tz_q;
  val_t                   mx1, mx2, my1, my2, mz1, mz2;
  cam_t                   xc_d, yc_d, zc_d, xc_q, yc_q, zc_q;
  val_t                   xn, yn, sqx, sqy, r2_q, r4, k1r2, k2r4, dist_q;
  logic [MUL_LAT-1:0][VAL_W-1:0] k1r2_q;
  logic [XN_DLY-1:0][VAL_W-1:0]  xn_q, yn_q;
  val_t                   xd, yd, fu, fv;
  logic signed [PIX_W-1:0] pu_q, pv_q;
  logic                   inv_q;

  function automatic logic [PIX_W-1:0] clamp32(val_t v);
    if (v > S32_MAX) begin
      return S32_MAX[PIX_W-1:0];
    end else if (v < S32_MIN) begin
      return S32_MIN[PIX_W-1:0];
    end
    return v[PIX_W-1:0];
  endfunction

  assign en         = !(valid_q[TOTAL_LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 31'd65536;
      focal_y_q  <= 31'd65536;
      center_u_q <= '0;
      center_v_q <= '0;
      dist_k1_q  <= '0;
      dist_k2_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FOCAL_X:  focal_x_q  <= cfg_data_i[30:0];
        REG_FOCAL_Y:  focal_y_q  <= cfg_data_i[30:0];
        REG_CENTER_U: center_u_q <= cfg_data_i;
        REG_CENTER_V: center_v_q <= cfg_data_i;
        REG_DIST_K1:  dist_k1_q  <= cfg_data_i;
        REG_DIST_K2:  dist_k2_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOTAL_LAT-2:0], in_valid_i};
    end
  end

  // camera frame
  prj_mul #(.Shift(CAM_SHIFT)) u_mx1 (.clk_i, .en_i(en), .a_i(val_t'(rot_11_i)),
                                      .b_i(val_t'(world_x_i)), .p_o(mx1));
  prj_mul #(.Shift(CAM_SHIFT)) u_mx2 (.clk_i, .en_i(en), .a_i(val_t'(rot_12_i)),
                                      .b_i(val_t'(world_y_i)), .p_o(mx2));
  prj_mul #(.Shift(CAM_SHIFT)) u_my1 (.clk_i, .en_i(en), .a_i(val_t'(rot_21_i)),
                                      .b_i(val_t'(world_x_i)), .p_o(my1));
  prj_mul #(.Shift(CAM_SHIFT)) u_my2 (.clk_i, .en_i(en), .a_i(val_t'(rot_22_i)),
                                      .b_i(val_t'(world_y_i)), .p_o(my2));
  prj_mul #(.Shift(CAM_SHIFT)) u_mz1 (.clk_i, .en_i(en), .a_i(val_t'(rot_31_i)),
                                      .b_i(val_t'(world_x_i)), .p_o(mz1));
  prj_mul #(.Shift(CAM_SHIFT)) u_mz2 (.clk_i, .en_i(en), .a_i(val_t'(rot_32_i)),
                                      .b_i(val_t'(world_y_i)), .p_o(mz2));

  always_comb begin
    xc_d = cam_t'(mx1) + cam_t'(mx2) + (cam_t'($signed(tx_q[MUL_LAT-1])) <<< TRANS_SHIFT);
    yc_d = cam_t'(my1) + cam_t'(my2) + (cam_t'($signed(ty_q[MUL_LAT-1])) <<< TRANS_SHIFT);
    zc_d = cam_t'(mz1) + cam_t'(mz2) + (cam_t'($signed(tz_q[MUL_LAT-1])) <<< TRANS_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q[0] <= trans_x_i;
      ty_q[0] <= trans_y_i;
      tz_q[0] <= trans_z_i;
      for (int i = 1; i < MUL_LAT; i++) begin
        tx_q[i] <= tx_q[i-1];
        ty_q[i] <= ty_q[i-1];
        tz_q[i] <= tz_q[i-1];
      end
      xc_q      <= xc_d;
      yc_q      <= yc_d;
      zc_q      <= zc_d;
      flag_q[0] <= zc_d[CAM_W-1] || (zc_d == '0);
      for (int i = 1; i < FLAG_DLY; i++) begin
        flag_q[i] <= flag_q[i-1];
      end
    end
  end

  // perspective divide
  prj_div u_div (.clk_i, .en_i(en), .num_x_i(xc_q), .num_y_i(yc_q), .den_i(zc_q),
                 .quo_x_o(xn), .quo_y_o(yn));

  // distortion factor
  prj_mul #(.Shift(FRAC)) u_sqx (.clk_i, .en_i(en), .a_i(xn), .b_i(xn), .p_o(sqx));
  prj_mul #(.Shift(FRAC)) u_sqy (.clk_i, .en_i(en), .a_i(yn), .b_i(yn), .p_o(sqy));
  prj_mul #(.Shift(FRAC)) u_r4 (.clk_i, .en_i(en), .a_i(r2_q), .b_i(r2_q), .p_o(r4));
  prj_mul #(.Shift(FRAC)) u_k1 (.clk_i, .en_i(en), .a_i(val_t'(dist_k1_q)), .b_i(r2_q),
                                .p_o(k1r2));
  prj_mul #(.Shift(FRAC)) u_k2 (.clk_i, .en_i(en), .a_i(val_t'(dist_k2_q)), .b_i(r4),
                                .p_o(k2r4));

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q      <= sat_add(sqx, sqy);
      k1r2_q[0] <= k1r2;
      for (int i = 1; i < MUL_LAT; i++) begin
        k1r2_q[i] <= k1r2_q[i-1];
      end
      dist_q  <= sat_add(sat_add(ONE_Q24, val_t'(k1r2_q[MUL_LAT-1])), k2r4);
      xn_q[0] <= xn;
      yn_q[0] <= yn;
      for (int i = 1; i < XN_DLY; i++) begin
        xn_q[i] <= xn_q[i-1];
        yn_q[i] <= yn_q[i-1];
      end
    end
  end

  // distortion and pixel scaling
  prj_mul #(.Shift(FRAC)) u_xd (.clk_i, .en_i(en), .a_i(val_t'(xn_q[XN_DLY-1])),
                                .b_i(dist_q), .p_o(xd));
  prj_mul #(.Shift(FRAC)) u_yd (.clk_i, .en_i(en), .a_i(val_t'(yn_q[XN_DLY-1])),
                                .b_i(dist_q), .p_o(yd));
  prj_mul #(.Shift(FRAC)) u_fu (.clk_i, .en_i(en), .a_i(xd),
                                .b_i(val_t'({1'b0, focal_x_q})), .p_o(fu));
  prj_mul #(.Shift(FRAC)) u_fv (.clk_i, .en_i(en), .a_i(yd),
                                .b_i(val_t'({1'b0, focal_y_q})), .p_o(fv));

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q <= flag_q[FLAG_DLY-1];
      pu_q  <= flag_q[FLAG_DLY-1] ? PIX_SAT : clamp32(sat_add(fu, val_t'(center_u_q)));
      pv_q  <= flag_q[FLAG_DLY-1] ? PIX_SAT : clamp32(sat_add(fv, val_t'(center_v_q)));
    end
  end

  assign out_valid_o     = valid_q[TOTAL_LAT-1];
  assign pixel_u_o       = pu_q;
  assign pixel_v_o       = pv_q;
  assign depth_invalid_o = inv_q;

endmodule

[src/prj_chk.sv]
// Port-level checks for the projector core and their binding.
module prj_chk import prj_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [PIX_W-1:0] pixel_u_o,
  input logic signed [PIX_W-1:0] pixel_v_o,
  input logic                    depth_invalid_o
);

  localparam logic [PIX_W-1:0] PIX_SAT = 32'h7FFF_FFFF;

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_stall_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while the result is stalled");

  a_invalid_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_invalid_o) |-> (pixel_u_o == PIX_SAT && pixel_v_o == PIX_SAT))
    else $error("bad depth result not saturated");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pixel_u_o)
                                      && $stable(pixel_v_o) && $stable(depth_invalid_o)))
    else $error("stalled result changed");

endmodule

bind pinhole_radial_distortion_projector_core prj_chk u_prj_chk (.*);
